// ===== rtl/mgmt_command_byte_parser_unit_assert.svh =====
// Assertion macros for the management command byte parser.
`ifndef MGMT_COMMAND_BYTE_PARSER_UNIT_ASSERT_SVH
`define MGMT_COMMAND_BYTE_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MCBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcbp same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define MCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcbp next-cycle check failed");
`else
`define MCBP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MCBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/mcbp_pkg.sv =====
package mcbp_pkg;

   localparam int GET_TABLE_DEPTH = 4;
   localparam int SET_TABLE_DEPTH = 9;

   typedef enum logic [3:0] {
      PH_TYPE      = 4'd0,
      PH_CMD       = 4'd1,
      PH_COUNT     = 4'd2,
      PH_ARGS      = 4'd3,
      PH_DONE      = 4'd4,
      PH_BAD_TYPE  = 4'd5,
      PH_BAD_CMD   = 4'd6,
      PH_BAD_COUNT = 4'd7,
      PH_BAD_ARGS  = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE        = 2'd0,
      ST_OK          = 2'd1,
      ST_UNSUPPORTED = 2'd2,
      ST_MALFORMED   = 2'd3
   } status_type;

   localparam logic [1:0] KIND_GET  = 2'd0;
   localparam logic [1:0] KIND_SET  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // Classified request byte, as queued between front and back.
   typedef struct packed {
      logic [7:0] data;
      logic       type_ok;    // byte <= 2
      logic       get_ok;     // byte < GET_TABLE_DEPTH
      logic       set_ok;     // byte < SET_TABLE_DEPTH
      logic       is_zero;
      logic [1:0] set_count;  // argument count of set command (if set_ok)
   } byte_class_type;

   // Argument count for each set command.
   function automatic logic [1:0] set_arg_count(input logic [3:0] idx);
      logic [1:0] cnt;
      case (idx)
         4'd0:    cnt = 2'd2;
         4'd1:    cnt = 2'd1;
         4'd2:    cnt = 2'd2;
         4'd3:    cnt = 2'd1;
         4'd4:    cnt = 2'd1;
         4'd5:    cnt = 2'd1;
         4'd6:    cnt = 2'd1;
         4'd7:    cnt = 2'd1;
         4'd8:    cnt = 2'd1;
         default: cnt = 2'd0;
      endcase
      return cnt;
   endfunction

endpackage

// ===== rtl/mcbp_front.sv =====
module mcbp_front import mcbp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           q_pop,
   output logic           q_valid,
   output byte_class_type q_item
);

   byte_class_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push;
   byte_class_type cls;

   // Classify the byte on the way in.
   always_comb begin
      cls.data      = req_tdata;
      cls.type_ok   = (req_tdata <= 8'd2);
      cls.get_ok    = (req_tdata < 8'(GET_TABLE_DEPTH));
      cls.set_ok    = (req_tdata < 8'(SET_TABLE_DEPTH));
      cls.is_zero   = (req_tdata == 8'd0);
      cls.set_count = set_arg_count(req_tdata[3:0]);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/mcbp_back.sv =====
module mcbp_back import mcbp_pkg::*; #(
   parameter int ARG_STORE_BYTES = 128
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  byte_class_type q_item,
   output logic           q_pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [31:0]    rsp_tdata,
   output logic           rsp_tlast,
   output logic           rsp_tuser
);

   localparam logic [8:0] ARG_LIMIT = 9'(ARG_STORE_BYTES - 1);

   phase_type  phase_ff, phase_in;
   status_type status_ff, status_in;
   logic [1:0] kind_ff, kind_in;
   logic [3:0] cmd_ff, cmd_in;
   logic [1:0] expected_ff, expected_in;
   logic [1:0] remaining_ff, remaining_in;
   logic [7:0] bytes_read_ff, bytes_read_in;
   logic [7:0] arg_len_ff, arg_len_in;

   logic       out_valid_ff;
   logic [31:0] out_data_ff, out_data_in;
   logic       out_last_ff, out_last_in;
   logic       out_user_ff, out_user_in;

   logic       dvalid, dnum, dcomplete;
   logic [6:0] dpos;
   logic [7:0] dbyte;
   logic [7:0] br_inc;
   logic [1:0] rem_dec;
   logic       fin, fail;
   logic [7:0] b;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);
   assign b     = q_item.data;

   always_comb begin
      phase_in      = phase_ff;
      status_in     = status_ff;
      kind_in       = kind_ff;
      cmd_in        = cmd_ff;
      expected_in   = expected_ff;
      remaining_in  = remaining_ff;
      bytes_read_in = bytes_read_ff;
      arg_len_in    = arg_len_ff;
      dvalid        = 1'b0;
      dnum          = 1'b0;
      dpos          = 7'd0;
      dbyte         = 8'd0;
      dcomplete     = 1'b0;
      br_inc        = bytes_read_ff + 8'd1;
      rem_dec       = remaining_ff - 2'd1;
      case (phase_ff)
         PH_TYPE: begin
            if (q_item.type_ok) begin
               kind_in = b[1:0];
               if (b[1:0] == KIND_DONE) begin
                  status_in = ST_OK;
                  phase_in  = PH_DONE;
               end else begin
                  phase_in = PH_CMD;
               end
            end else begin
               phase_in = PH_BAD_TYPE;
            end
         end
         PH_CMD: begin
            if (kind_ff == KIND_GET && q_item.get_ok) begin
               cmd_in    = b[3:0];
               status_in = ST_OK;
               phase_in  = PH_DONE;
            end else if (kind_ff == KIND_SET && q_item.set_ok) begin
               cmd_in      = b[3:0];
               expected_in = q_item.set_count;
               phase_in    = PH_COUNT;
            end else begin
               status_in = ST_UNSUPPORTED;
               phase_in  = PH_BAD_CMD;
            end
         end
         PH_COUNT: begin
            if (!q_item.is_zero && b == {6'd0, expected_ff}) begin
               remaining_in  = b[1:0];
               bytes_read_in = 8'd0;
               arg_len_in    = 8'd0;
               phase_in      = PH_ARGS;
            end else begin
               status_in = ST_MALFORMED;
               phase_in  = PH_BAD_COUNT;
            end
         end
         PH_ARGS: begin
            if (arg_len_ff == bytes_read_ff) begin
               // Length byte of the next argument.
               bytes_read_in = 8'd0;
               arg_len_in    = b;
               if (q_item.is_zero) begin
                  status_in = ST_MALFORMED;
                  phase_in  = PH_BAD_ARGS;
               end
            end else if ({1'b0, bytes_read_ff} < ARG_LIMIT) begin
               dvalid        = 1'b1;
               dnum          = 1'(expected_ff - remaining_ff);
               dpos          = bytes_read_ff[6:0];
               dbyte         = b;
               bytes_read_in = br_inc;
               if (arg_len_ff == br_inc) begin
                  dcomplete    = 1'b1;
                  remaining_in = rem_dec;
                  if (rem_dec == 2'd0) begin
                     status_in = ST_OK;
                     phase_in  = PH_DONE;
                  end
               end
            end else begin
               status_in = ST_MALFORMED;
               phase_in  = PH_BAD_ARGS;
            end
         end
         default: begin
         end
      endcase
      fin  = (phase_in >= PH_DONE);
      fail = (phase_in >= PH_BAD_TYPE);
      out_data_in = {2'b00, dbyte, dpos, dnum, cmd_in, kind_in, fail, fin,
                     status_in, phase_in};
      out_last_in = dcomplete;
      out_user_in = dvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         status_ff     <= ST_NONE;
         kind_ff       <= 2'd0;
         cmd_ff        <= 4'd0;
         expected_ff   <= 2'd0;
         remaining_ff  <= 2'd0;
         bytes_read_ff <= 8'd0;
         arg_len_ff    <= 8'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff      <= phase_in;
            status_ff     <= status_in;
            kind_ff       <= kind_in;
            cmd_ff        <= cmd_in;
            expected_ff   <= expected_in;
            remaining_ff  <= remaining_in;
            bytes_read_ff <= bytes_read_in;
            arg_len_ff    <= arg_len_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_data_ff <= out_data_in;
         out_last_ff <= out_last_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ===== rtl/mgmt_command_byte_parser_unit.sv =====
// Path: an accepted request byte is written into the byte queue, then popped into the
// response register, which drives rsp_tvalid until the response transaction is taken.
// Throughput: one byte per cycle while responses are taken; the two-entry byte queue absorbs two more bytes
// while a response waits for rsp_tready, then req_tready drops.
// Reset: synchronous, active high; clears the parse state to "awaiting type byte",
// empties the byte queue and drops rsp_tvalid.
`include "mgmt_command_byte_parser_unit_assert.svh"

module mgmt_command_byte_parser_unit import mcbp_pkg::*; #(
   parameter int ARG_STORE_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] phase, [5:4] status, [6] finished, [7] failed, [9:8] req_kind,
   // [13:10] command_index, [14] arg_number, [21:15] arg_position,
   // [29:22] arg_data, [31:30] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,   // arg_complete
   output logic        rsp_tuser    // [0] arg_data_valid
);

   // Front to back: classified byte at the head of the queue.
   logic           q_valid;
   logic           q_pop;
   byte_class_type q_item;

   // Front: accept request bytes, precompute the range checks and the set-command
   // argument count, and queue them.
   mcbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_item     (q_item)
   );

   // Back: advance the parse state one byte per transaction and register the
   // response; stall (hold the queue head) while the response is not taken.
   mcbp_back #(
      .ARG_STORE_BYTES (ARG_STORE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The back end never drains an empty queue.
   `MCBP_ASSERT_IMPL(a_pop_needs_item, clock, reset, q_pop, q_valid)
   // Every consumed byte yields a response in the next cycle.
   `MCBP_ASSERT_NEXT(a_pop_gives_rsp, clock, reset, q_pop, rsp_tvalid)
   // An argument can only complete on a data byte.
   `MCBP_ASSERT_IMPL(a_last_is_data, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)
   // Data bytes come out only while parsing arguments or on the final byte.
   `MCBP_ASSERT_IMPL(a_data_phase, clock, reset, rsp_tvalid && rsp_tuser,
                     rsp_tdata[3:0] == PH_ARGS || rsp_tdata[3:0] == PH_DONE)

endmodule

// ===== tb/sv/tb.sv =====
import mcbp_pkg::*;

// Argument count of each set command, two bits per entry, entry 0 in the low bits.
localparam logic [17:0] SET_ARG_COUNT_TABLE = {
   2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2
};
localparam int ARG_STORE_BYTES = 128;

// Response word as it sits in rsp_tdata, most significant field first.
typedef struct packed {
   logic [1:0] reserved;
   logic [7:0] data;
   logic [6:0] position;
   logic       number;
   logic [3:0] command;
   logic [1:0] kind;
   logic       failed;
   logic       finished;
   status_type status;
   phase_type  phase;
} reply_word_type;

typedef struct {
   reply_word_type word;
   logic           complete;     // rsp_tlast
   logic           data_valid;   // rsp_tuser[0]
} reply_type;

// Tracks the parse state of the request stream and the responses it must produce.
class reply_scoreboard;
   phase_type  phase = PH_TYPE;
   status_type status = ST_NONE;
   logic [1:0] kind = '0;
   logic [3:0] command = '0;
   logic [1:0] args_expected = '0;
   logic [1:0] args_left = '0;
   logic [7:0] bytes_read = '0;
   logic [7:0] arg_length = '0;
   reply_type  pending_replies[$];
   int         errors = 0;

   function reply_type parse_request_byte(logic [7:0] b);
      reply_type  r;
      logic [1:0] arg_diff;
      r.word = '0;
      r.complete = 1'b0;
      r.data_valid = 1'b0;
      case (phase)
         PH_TYPE: begin
            if (b <= 8'd2) begin
               kind = b[1:0];
               if (b[1:0] == KIND_DONE) begin
                  status = ST_OK;
                  phase = PH_DONE;
               end else begin
                  phase = PH_CMD;
               end
            end else begin
               phase = PH_BAD_TYPE;
            end
         end
         PH_CMD: begin
            if (kind == KIND_GET && b < GET_TABLE_DEPTH) begin
               command = b[3:0];
               status = ST_OK;
               phase = PH_DONE;
            end else if (kind == KIND_SET && b < SET_TABLE_DEPTH) begin
               command = b[3:0];
               args_expected = SET_ARG_COUNT_TABLE[2*b +: 2];
               phase = PH_COUNT;
            end else begin
               status = ST_UNSUPPORTED;
               phase = PH_BAD_CMD;
            end
         end
         PH_COUNT: begin
            if (b != 8'd0 && b == {6'd0, args_expected}) begin
               args_left = b[1:0];
               bytes_read = '0;
               arg_length = '0;
               phase = PH_ARGS;
            end else begin
               status = ST_MALFORMED;
               phase = PH_BAD_COUNT;
            end
         end
         PH_ARGS: begin
            if (arg_length == bytes_read) begin
               // length byte of the next argument
               bytes_read = '0;
               arg_length = b;
               if (b == 8'd0) begin
                  status = ST_MALFORMED;
                  phase = PH_BAD_ARGS;
               end
            end else if (bytes_read < ARG_STORE_BYTES - 1) begin
               arg_diff = args_expected - args_left;
               r.data_valid = 1'b1;
               r.word.number = arg_diff[0];
               r.word.position = bytes_read[6:0];
               r.word.data = b;
               bytes_read = bytes_read + 8'd1;
               if (arg_length == bytes_read) begin
                  r.complete = 1'b1;
                  args_left = args_left - 2'd1;
                  if (args_left == 2'd0) begin
                     status = ST_OK;
                     phase = PH_DONE;
                  end
               end
            end else begin
               status = ST_MALFORMED;
               phase = PH_BAD_ARGS;
            end
         end
         default: ;
      endcase
      r.word.phase = phase;
      r.word.status = status;
      r.word.finished = (phase >= PH_DONE);
      r.word.failed = (phase >= PH_BAD_TYPE);
      r.word.kind = kind;
      r.word.command = command;
      return r;
   endfunction

   function void note_request(logic [7:0] b);
      pending_replies.push_back(parse_request_byte(b));
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   function void check_reply(logic [31:0] tdata, logic tlast, logic tuser);
      reply_type      want;
      reply_word_type got;
      got = reply_word_type'(tdata);
      if (pending_replies.size() == 0) begin
         $error("response transaction with no request waiting");
         errors++;
         return;
      end
      want = pending_replies.pop_front();
      compare_field("phase", want.word.phase, got.phase);
      compare_field("status", want.word.status, got.status);
      compare_field("finished", want.word.finished, got.finished);
      compare_field("failed", want.word.failed, got.failed);
      compare_field("req_kind", want.word.kind, got.kind);
      compare_field("command_index", want.word.command, got.command);
      compare_field("arg_number", want.word.number, got.number);
      compare_field("arg_position", want.word.position, got.position);
      compare_field("arg_data", want.word.data, got.data);
      compare_field("reserved", want.word.reserved, got.reserved);
      compare_field("arg_data_valid", want.data_valid, tuser);
      compare_field("arg_complete", want.complete, tlast);
   endfunction
endclass

module tb;

   localparam int TOTAL_ITEMS = 720;
   localparam int MODE_ITEMS = TOTAL_ITEMS / 3;
   localparam int LONGEST_ARG = ARG_STORE_BYTES - 1;
   localparam logic [7:0] TYPE_SET = {6'd0, KIND_SET};
   localparam logic [7:0] SET_CMD_ADD_USER = 8'd0;   // takes two arguments
   localparam logic [7:0] ADD_USER_ARGS = 8'd2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int sent_count = 0;
   int tx_idle_pct = 18;
   int rx_idle_pct = 45;
   int second_len;
   int second_bytes;

   reply_scoreboard sb;

   mgmt_command_byte_parser_unit #(
      .ARG_STORE_BYTES(ARG_STORE_BYTES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random, decided at each falling edge.
   initial rsp_tready = 1'b0;
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rx_idle_pct);
   end

   // Check every response transaction at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_reply(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // Send one request byte; pick the idle profile from how far the run has got:
   // receiver-heavy idling first, then sender-heavy, then none at all.
   task automatic send_byte(input logic [7:0] value);
      if (sent_count < MODE_ITEMS) begin
         tx_idle_pct = 18;
         rx_idle_pct = 45;
      end else if (sent_count < 2 * MODE_ITEMS) begin
         tx_idle_pct = 45;
         rx_idle_pct = 18;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = value;
      do @(posedge clock); while (!req_tready);
      sb.note_request(value);
      sent_count++;
      @(negedge clock);
   endtask

   // Hold the request side quiet until every response has come back.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (sb.pending_replies.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      sb = new;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening: a set of the two-argument command, first argument at
      // the longest length the store takes, data bytes starting at the extremes.
      send_byte(TYPE_SET);
      send_byte(SET_CMD_ADD_USER);
      send_byte(ADD_USER_ARGS);
      send_byte(LONGEST_ARG[7:0]);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h55);
      send_byte(8'hAA);

      // Let the pipeline empty once mid-argument.
      wait_drained();

      // Rest of the first argument with random content; last byte lands on the
      // top position.
      repeat (LONGEST_ARG - 4) send_byte(8'($urandom_range(255)));

      // Second argument: mostly a legal length, sometimes zero, sometimes longer
      // than the store so the overflow byte trips the error.
      case ($urandom_range(15))
         0: second_len = 0;
         1, 2: second_len = $urandom_range(255, ARG_STORE_BYTES);
         default: second_len = $urandom_range(LONGEST_ARG, 1);
      endcase
      second_bytes = (second_len > LONGEST_ARG) ? ARG_STORE_BYTES : second_len;
      send_byte(second_len[7:0]);
      repeat (second_bytes) send_byte(8'($urandom_range(255)));

      // Request has ended (done or error); everything after must leave the held
      // state alone.
      send_byte(8'h00);
      send_byte(8'hFF);
      while (sent_count < TOTAL_ITEMS) send_byte(8'($urandom_range(255)));

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pending_replies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
